[rtl/core/airm_pkg.sv]
// Shared types and constants of the affine index range map.
// Holds field widths, register indexes and the stage records passed along the divider row.
// Depends on nothing.
package airm_pkg;

    localparam int INDEX_WIDTH_DEF = 32;

    localparam int START_W   = 32;
    localparam int SIZE_W    = 31;
    localparam int CFG_W     = 32;
    localparam int SPAN_W    = 31;
    localparam int DIVISOR_W = 31;
    localparam int RESULT_W  = 64;

    // Lower and upper input ends, wide enough for start + size - 1.
    localparam int A_W = 33;

    // Magnitude of a 64-bit signed end after the sign fold; one cell per quotient bit.
    localparam int DIVIDEND_W = 63;
    localparam int DIV_STEPS  = DIVIDEND_W;

    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 128;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_SCALE       = 2'd0;
    localparam logic [1:0] REG_BASE_OFFSET = 2'd1;
    localparam logic [1:0] REG_SPAN_LENGTH = 2'd2;
    localparam logic [1:0] REG_DIVISOR     = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]  scale;
        logic [CFG_W-1:0]  base_offset;
        logic [SPAN_W-1:0] span_length;
    } airm_cfg_t;

    // One end of the interval on its way through the divider row. The bits field
    // starts as the dividend and fills up with quotient bits from the bottom.
    typedef struct packed {
        logic                  neg;
        logic [DIVISOR_W-1:0]  rem;
        logic [DIVIDEND_W-1:0] bits;
    } airm_lane_t;

    typedef struct packed {
        logic       valid;
        airm_lane_t lo;
        airm_lane_t hi;
    } airm_stage_t;

    typedef struct packed {
        logic advance;
        logic skid_full;
    } airm_flow_t;

endpackage

[rtl/core/airm_front.sv]
// Front end of the affine index range map: interval ends, scaling and offsets.
// Two register stages; feeds the first divider cell. Depends on airm_pkg.
module airm_front #(
    parameter int INDEX_WIDTH = airm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [airm_pkg::START_W-1:0] chunk_start,
    input  logic [airm_pkg::SIZE_W-1:0]  chunk_size,
    input  airm_pkg::airm_cfg_t          cfg,
    output airm_pkg::airm_stage_t        stage_out
);
    import airm_pkg::*;

    logic signed [A_W-1:0]     a0;
    logic signed [A_W-1:0]     a1;
    logic signed [A_W-1:0]     end_lo;
    logic signed [A_W-1:0]     end_hi;
    logic signed [CFG_W-1:0]   sc;
    logic signed [A_W+CFG_W-1:0] prod_lo;
    logic signed [A_W+CFG_W-1:0] prod_hi;
    logic [RESULT_W-1:0]       off64;
    logic [RESULT_W-1:0]       ext64;
    logic [RESULT_W-1:0]       off_ext;
    logic [RESULT_W-1:0]       b_lo;
    logic [RESULT_W-1:0]       b_hi;

    logic                      v1_reg;
    logic                      v2_reg;
    logic [RESULT_W-1:0]       p_lo_reg;
    logic [RESULT_W-1:0]       p_hi_reg;
    airm_lane_t                lo_reg;
    airm_lane_t                hi_reg;

    always_comb begin
        a0 = {{(A_W-INDEX_WIDTH){chunk_start[INDEX_WIDTH-1]}}, chunk_start[INDEX_WIDTH-1:0]};
        a1 = a0 + A_W'(chunk_size) - A_W'(1);
        sc = signed'(cfg.scale);
        // A negative scale swaps which input end lands low.
        end_lo = sc[CFG_W-1] ? a1 : a0;
        end_hi = sc[CFG_W-1] ? a0 : a1;
        prod_lo = (A_W+CFG_W)'(sc) * (A_W+CFG_W)'(end_lo);
        prod_hi = (A_W+CFG_W)'(sc) * (A_W+CFG_W)'(end_hi);
        off64   = {{(RESULT_W-CFG_W){cfg.base_offset[CFG_W-1]}}, cfg.base_offset};
        ext64   = RESULT_W'(cfg.span_length) - RESULT_W'(1);
        off_ext = off64 + ext64;
        b_lo    = p_lo_reg + off64;
        b_hi    = p_hi_reg + off_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Negative ends are folded to ~n so the divider only sees magnitudes;
    // floor(n / d) is then ~(~n / d).
    always_ff @(posedge aclk) begin
        if (en) begin
            p_lo_reg    <= prod_lo[RESULT_W-1:0];
            p_hi_reg    <= prod_hi[RESULT_W-1:0];
            lo_reg.neg  <= b_lo[RESULT_W-1];
            lo_reg.rem  <= '0;
            lo_reg.bits <= b_lo[RESULT_W-1] ? ~b_lo[DIVIDEND_W-1:0] : b_lo[DIVIDEND_W-1:0];
            hi_reg.neg  <= b_hi[RESULT_W-1];
            hi_reg.rem  <= '0;
            hi_reg.bits <= b_hi[RESULT_W-1] ? ~b_hi[DIVIDEND_W-1:0] : b_hi[DIVIDEND_W-1:0];
        end
    end

    assign stage_out = '{valid: v2_reg, lo: lo_reg, hi: hi_reg};

endmodule

[rtl/core/airm_div_cell.sv]
// One cell of the divider row: a restoring division step on both interval ends.
// Produces one quotient bit per end and passes the stage on. Depends on airm_pkg.
module airm_div_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic [airm_pkg::DIVISOR_W-1:0] divisor,
    input  airm_pkg::airm_stage_t          stage_in,
    output airm_pkg::airm_stage_t          stage_out
);
    import airm_pkg::*;

    logic       valid_reg;
    airm_lane_t lo_reg;
    airm_lane_t hi_reg;

    function automatic airm_lane_t div_step(airm_lane_t l, logic [DIVISOR_W-1:0] d);
        logic [DIVISOR_W:0]   trial;
        logic [DIVISOR_W+1:0] diff;
        airm_lane_t           r;
        trial  = {l.rem, l.bits[DIVIDEND_W-1]};
        diff   = {1'b0, trial} - {2'b00, d};
        r.neg  = l.neg;
        r.rem  = diff[DIVISOR_W+1] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
        r.bits = {l.bits[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= div_step(stage_in.lo, divisor);
            hi_reg <= div_step(stage_in.hi, divisor);
        end
    end

    assign stage_out = '{valid: valid_reg, lo: lo_reg, hi: hi_reg};

endmodule

[rtl/core/airm_out.sv]
// Result stage of the affine index range map: sign unfold, size, output register and skid.
// Takes the last divider cell's stage. Depends on airm_pkg.
module airm_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  airm_pkg::airm_stage_t         stage_in,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [airm_pkg::M_DATA_W-1:0] m_tdata,
    output airm_pkg::airm_flow_t          flow
);
    import airm_pkg::*;

    logic [RESULT_W-1:0] r_lo;
    logic [RESULT_W-1:0] r_hi;
    logic [M_DATA_W-1:0] pipe_data;

    logic                m_valid_reg;
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] skid_data_reg;

    always_comb begin
        r_lo = stage_in.lo.neg ? ~{1'b0, stage_in.lo.bits} : {1'b0, stage_in.lo.bits};
        r_hi = stage_in.hi.neg ? ~{1'b0, stage_in.hi.bits} : {1'b0, stage_in.hi.bits};
        pipe_data = {r_hi - r_lo + RESULT_W'(1), r_lo};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (!m_valid_reg || m_tready) begin
                m_valid_reg <= stage_in.valid;
            end else if (stage_in.valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (!m_valid_reg || m_tready) begin
                m_data_reg <= pipe_data;
            end else begin
                skid_data_reg <= pipe_data;
            end
        end else if (m_tready) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = m_data_reg;
    assign flow.advance   = !skid_valid_reg;
    assign flow.skid_full = skid_valid_reg;

endmodule

[rtl/core/affine_index_range_map.sv]
// Top level of the affine index range map: configuration registers, front end,
// the divider cell row and the result stage. Depends on airm_pkg, airm_front,
// airm_div_cell and airm_out.
//
//  Channel   Direction  Handshake        Content
//  s_        in         tvalid/tready    one input interval (chunk_start, chunk_size)
//  m_        out        tvalid/tready    one mapped interval (range_start, range_size)
//  APB       in         psel/penable     scale, base_offset, span_length, divisor
//
// One beat is taken per cycle while s_tready is high, and every input beat yields
// exactly one result beat. A beat passes the multiplier register, the offset-add register,
// the divider row (one cell per quotient bit) and the output register.
// Reset is synchronous and active low; it clears all valid flags and loads the
// register defaults (scale 1, offset 0, span length 1, divisor 1).
// When m_tready drops, one more beat lands in the skid register, after which
// s_tready falls and the whole pipeline holds until the skid drains.
module affine_index_range_map #(
    parameter int INDEX_WIDTH = airm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata fields from bit 0 up: chunk_start[31:0], chunk_size[62:32], zero pad [63].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [airm_pkg::S_DATA_W-1:0]   s_tdata,
    // m_tdata fields from bit 0 up: range_start[63:0], range_size[127:64].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [airm_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [airm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [airm_pkg::CFG_W-1:0]      pwdata,
    output logic [airm_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);
    import airm_pkg::*;

    logic [CFG_W-1:0]     scale_reg;
    logic [CFG_W-1:0]     base_offset_reg;
    logic [SPAN_W-1:0]    span_length_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    logic                 cfg_wr;
    logic [1:0]           reg_index;
    logic [DIVISOR_W-1:0] div_eff;
    airm_cfg_t            cfg;
    airm_flow_t           flow;
    airm_stage_t          chain [0:DIV_STEPS];

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    // The byte offset within a word is ignored, so every address hits a register.
    assign reg_index = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= CFG_W'(1);
            base_offset_reg <= '0;
            span_length_reg <= SPAN_W'(1);
            divisor_reg     <= DIVISOR_W'(1);
        end else if (cfg_wr) begin
            case (reg_index)
                REG_SCALE:       scale_reg       <= pwdata;
                REG_BASE_OFFSET: base_offset_reg <= pwdata;
                REG_SPAN_LENGTH: span_length_reg <= pwdata[SPAN_W-1:0];
                REG_DIVISOR:     divisor_reg     <= pwdata[DIVISOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SCALE:       prdata = scale_reg;
            REG_BASE_OFFSET: prdata = base_offset_reg;
            REG_SPAN_LENGTH: prdata = {1'b0, span_length_reg};
            REG_DIVISOR:     prdata = {1'b0, divisor_reg};
            default:         prdata = '0;
        endcase
    end

    // A divisor of zero behaves as one. Dividing by one passes the ends through
    // unchanged, so the row runs the same way for every divisor.
    assign div_eff = (divisor_reg == '0) ? DIVISOR_W'(1) : divisor_reg;

    assign cfg = '{scale: scale_reg, base_offset: base_offset_reg,
                   span_length: span_length_reg};

    // The whole pipeline moves together; only the skid register can hold it.
    assign s_tready = flow.advance;

    airm_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (flow.advance),
        .in_valid    (s_tvalid),
        .chunk_start (s_tdata[START_W-1:0]),
        .chunk_size  (s_tdata[START_W+SIZE_W-1:START_W]),
        .cfg         (cfg),
        .stage_out   (chain[0])
    );

    // Divider row: cell i decides quotient bit DIVIDEND_W-1-i of both ends.
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        airm_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (flow.advance),
            .divisor   (div_eff),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    airm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stage_in (chain[DIV_STEPS]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .flow     (flow)
    );

    // A beat parked in the skid always has one in the output register ahead of it.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        flow.skid_full |-> m_tvalid)
        else $error("skid holds a beat while the output register is empty");

    // The skid only fills when the output beat was stalled in the cycle before.
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(flow.skid_full) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without a stalled output beat");

    // A parked beat is not dropped, and no input is taken, while the sink keeps stalling.
    a_skid_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        flow.skid_full && !m_tready |=> flow.skid_full && !s_tready)
        else $error("skid beat lost or input taken while skid is full");

endmodule

[dv/tb_affine_index_range_map.sv]
// Self-checking testbench for affine_index_range_map: a directed table, then random
// beats under several gap and stall patterns, checked against typed-in or modelled results.
// Depends on airm_pkg and the affine_index_range_map RTL.
module tb_affine_index_range_map;

    timeunit 1ns;
    timeprecision 1ps;

    import airm_pkg::*;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic [30:0]        U31_MAX = 31'h7FFF_FFFF;

    localparam int BEATS_PER_PHASE = 150;
    localparam int RANDOM_PHASES   = 13;
    // Long enough to fill the 66-stage pipeline and the skid, so s_tready must fall.
    localparam int HOLD_CYCLES     = 300;
    // Pipeline depth plus some margin, waited out once everything has come back.
    localparam int TAIL_CYCLES     = 80;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    // Which side inserts bubbles during a phase.
    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SRC,
        GAP_SNK,
        GAP_BOTH
    } gap_mode_t;

    typedef struct {
        longint range_start;
        longint range_size;
    } mapped_range_t;

    // One row of the directed table: the register set it needs, the input interval,
    // and, where it is obvious, the result typed in by hand.
    typedef struct {
        logic signed [31:0] scale;
        logic signed [31:0] offset;
        logic [30:0]        span;
        logic [30:0]        divisor;
        logic signed [31:0] chunk_start;
        logic [30:0]        chunk_size;
        bit                 known;
        longint             want_start;
        longint             want_size;
    } probe_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // Fields from bit 0 up: chunk_start[31:0], chunk_size[62:32], zero pad [63].
    logic [S_DATA_W-1:0]     s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // Fields from bit 0 up: range_start[63:0], range_size[127:64].
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_W-1:0]        pwdata   = '0;
    logic [CFG_W-1:0]        prdata;
    logic                    pready;

    // Shadow copy of the register file as the block should hold it.
    logic signed [31:0] cfg_scale   = 32'sd1;
    logic signed [31:0] cfg_offset  = 32'sd0;
    logic [30:0]        cfg_span    = 31'd1;
    logic [30:0]        cfg_divisor = 31'd1;

    mapped_range_t pending_ranges[$];
    int            mismatch_count = 0;
    gap_mode_t     gap_mode       = GAP_NONE;
    bit            hold_armed     = 1'b0;
    bit            hold_used      = 1'b0;
    int            hold_left      = 0;

    // Directed table. Rows under the reset registers map an interval onto itself;
    // rows with zero scale give the fixed span whatever the input is.
    probe_t probes [21] = '{
        // Reset registers, including the empty chunk and the field extremes.
        '{32'sd1, 32'sd0, 31'd1, 31'd1, 32'sd0, 31'd1, 1'b1, 64'sd0, 64'sd1},
        '{32'sd1, 32'sd0, 31'd1, 31'd1, S32_MIN, 31'd0, 1'b1, S32_MIN, 64'sd0},
        '{32'sd1, 32'sd0, 31'd1, 31'd1, S32_MAX, U31_MAX, 1'b1, S32_MAX, 64'sd2147483647},
        '{32'sd1, 32'sd0, 31'd1, 31'd1, S32_MIN, U31_MAX, 1'b1, S32_MIN, 64'sd2147483647},
        '{32'sd1, 32'sd0, 31'd1, 31'd1, -32'sd1, 31'd0, 1'b1, -64'sd1, 64'sd0},
        // Zero scale: the interval sits at the offset; span zero leaves it empty.
        '{32'sd0, 32'sd5, 31'd0, 31'd1, 32'sd7, 31'd3, 1'b1, 64'sd5, 64'sd0},
        '{32'sd0, 32'sd5, 31'd0, 31'd1, S32_MIN, U31_MAX, 1'b1, 64'sd5, 64'sd0},
        '{32'sd0, S32_MIN, U31_MAX, 31'd1, 32'sd123, 31'd9, 1'b1, S32_MIN,
          64'sd2147483647},
        // Negative scale swaps the ends, also for an empty chunk.
        '{-32'sd1, 32'sd0, 31'd1, 31'd1, 32'sd10, 31'd4, 1'b0, 64'sd0, 64'sd0},
        '{-32'sd1, 32'sd100, 31'd0, 31'd1, -32'sd5, 31'd0, 1'b0, 64'sd0, 64'sd0},
        // A divisor of zero behaves as one.
        '{32'sd3, -32'sd7, 31'd2, 31'd0, 32'sd11, 31'd5, 1'b0, 64'sd0, 64'sd0},
        '{-32'sd3, -32'sd7, 31'd2, 31'd0, -32'sd11, 31'd5, 1'b0, 64'sd0, 64'sd0},
        // Floor division rounds negative ends down.
        '{32'sd5, -32'sd3, 31'd4, 31'd7, -32'sd20, 31'd6, 1'b0, 64'sd0, 64'sd0},
        '{-32'sd5, 32'sd3, 31'd4, 31'd7, 32'sd20, 31'd0, 1'b0, 64'sd0, 64'sd0},
        '{-32'sd1, -32'sd1, 31'd1, 31'd2, -32'sd1, 31'd1, 1'b0, 64'sd0, 64'sd0},
        '{32'sd1, 32'sd0, 31'd1, 31'd3, -32'sd4, 31'd2, 1'b0, 64'sd0, 64'sd0},
        // Register and field extremes together.
        '{S32_MAX, S32_MAX, U31_MAX, U31_MAX, S32_MAX, U31_MAX, 1'b0, 64'sd0, 64'sd0},
        '{S32_MIN, S32_MIN, U31_MAX, U31_MAX, S32_MAX, U31_MAX, 1'b0, 64'sd0, 64'sd0},
        '{S32_MIN, S32_MIN, 31'd0, 31'd2, S32_MIN, 31'd0, 1'b0, 64'sd0, 64'sd0},
        '{S32_MIN, S32_MAX, U31_MAX, 31'd1, S32_MIN, U31_MAX, 1'b0, 64'sd0, 64'sd0},
        '{S32_MAX, S32_MIN, 31'd0, 31'd1, S32_MIN, U31_MAX, 1'b0, 64'sd0, 64'sd0}
    };

    affine_index_range_map dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Floor division for a positive divisor; the language truncates toward zero.
    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Covering output interval of [chunk_start, chunk_start + chunk_size - 1] under
    // the current registers. All sums wrap at 64 bits, as in the hardware.
    function automatic mapped_range_t map_interval(input logic signed [31:0] chunk_start,
                                                   input logic [30:0] chunk_size);
        longint        lo_in, hi_in, sc, off, ext, lo_out, hi_out, den;
        mapped_range_t r;
        lo_in = longint'(chunk_start);
        hi_in = lo_in + longint'({33'd0, chunk_size}) - 1;
        sc    = longint'(cfg_scale);
        off   = longint'(cfg_offset);
        ext   = longint'({33'd0, cfg_span}) - 1;
        if (sc > 0) begin
            lo_out = sc * lo_in + off;
            hi_out = sc * hi_in + off + ext;
        end else if (sc < 0) begin
            lo_out = sc * hi_in + off;
            hi_out = sc * lo_in + off + ext;
        end else begin
            lo_out = off;
            hi_out = off + ext;
        end
        // Divisors of zero and one leave the ends alone.
        if (cfg_divisor > 31'd1) begin
            den    = longint'({33'd0, cfg_divisor});
            lo_out = floor_quot(lo_out, den);
            hi_out = floor_quot(hi_out, den);
        end
        r.range_start = lo_out;
        r.range_size  = hi_out - lo_out + 1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // Mostly uniform words, with a share of small values and the signed extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 4))
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 64) - 32;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return S32_MIN;
                    1:       return S32_MAX;
                    2:       return 32'd0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [30:0] pick_u31();
        case ($urandom_range(0, 4))
            0, 1, 2: return 31'($urandom & 32'h7FFF_FFFF);
            3:       return 31'($urandom_range(0, 40));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 31'd0;
                    1:       return 31'd1;
                    2:       return U31_MAX - 31'd1;
                    default: return U31_MAX;
                endcase
            end
        endcase
    endfunction

    function automatic logic [30:0] pick_divisor();
        case ($urandom_range(0, 4))
            0:       return 31'd1;
            1, 2:    return 31'($urandom_range(2, 16));
            3:       return 31'($urandom_range(17, 100000));
            default: return pick_u31();
        endcase
    endfunction

    function automatic bit sender_idles();
        case (gap_mode)
            GAP_SRC:  return $urandom_range(0, 99) < 84;
            GAP_BOTH: return $urandom_range(0, 99) < 34;
            default:  return 1'b0;
        endcase
    endfunction

    // APB write with a setup and an access phase: the register takes the value at the end of the access cycle.
    // The bus then rests idle before the next transfer.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCALE:       cfg_scale   = value;
            REG_BASE_OFFSET: cfg_offset  = value;
            REG_SPAN_LENGTH: cfg_span    = value[30:0];
            REG_DIVISOR:     cfg_divisor = value[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drops s_tvalid and waits until every outstanding result has come back. Since
    // every beat yields a result, the pipeline is then empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic apply_config(input logic signed [31:0] scale,
                                input logic signed [31:0] offset,
                                input logic [30:0] span, input logic [30:0] divisor);
        settle();
        apply_reg: begin
            apb_write(REG_SCALE, scale);
            apb_write(REG_BASE_OFFSET, offset);
            apb_write(REG_SPAN_LENGTH, {1'b0, span});
            apb_write(REG_DIVISOR, {1'b0, divisor});
        end
    endtask

    // Offers one beat, possibly after a few bubbles, and records the expected result
    // at the edge where the block takes it. s_tvalid stays high on return so that
    // back-to-back beats need no second assignment in the same step.
    task automatic send_chunk(input logic signed [31:0] chunk_start,
                              input logic [30:0] chunk_size, input bit known,
                              input longint want_start, input longint want_size);
        mapped_range_t want;
        while (sender_idles()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, chunk_size, chunk_start};
        do @(posedge aclk); while (!s_tready);
        if (known) begin
            want.range_start = want_start;
            want.range_size  = want_size;
        end else begin
            want = map_interval(chunk_start, chunk_size);
        end
        pending_ranges.push_back(want);
    endtask

    // Result side: random back-pressure by phase, plus one long hold-off that lets
    // the pipeline fill up and stall the input channel.
    always @(posedge aclk) begin
        if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (gap_mode)
                GAP_SNK:  m_tready <= ($urandom_range(0, 99) >= 84);
                GAP_BOTH: m_tready <= ($urandom_range(0, 99) >= 34);
                default:  m_tready <= 1'b1;
            endcase
        end
    end

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        mapped_range_t want;
        longint        got_start, got_size;
        if (aresetn && m_tvalid && m_tready) begin
            got_start = m_tdata[63:0];
            got_size  = m_tdata[127:64];
            if (pending_ranges.size() == 0) begin
                report_mismatch("result beat with none expected", got_start, 0);
            end else begin
                want = pending_ranges.pop_front();
                if (got_start != want.range_start) begin
                    report_mismatch("range_start", got_start, want.range_start);
                end
                if (got_size != want.range_size) begin
                    report_mismatch("range_size", got_size, want.range_size);
                end
            end
        end
    end

    initial begin
        logic signed [31:0] c_scale, c_offset;
        logic [30:0]        c_span, c_div;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: registers are rewritten only when a row needs other values.
        foreach (probes[i]) begin
            if (probes[i].scale !== cfg_scale || probes[i].offset !== cfg_offset ||
                probes[i].span !== cfg_span || probes[i].divisor !== cfg_divisor) begin
                apply_config(probes[i].scale, probes[i].offset, probes[i].span,
                             probes[i].divisor);
            end
            send_chunk(probes[i].chunk_start, probes[i].chunk_size, probes[i].known,
                       probes[i].want_start, probes[i].want_size);
        end

        // Random part: each phase gets its own register set and gap pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    c_scale = S32_MIN; c_offset = S32_MIN; c_span = 31'd0; c_div = 31'd1;
                end
                1: begin
                    c_scale = S32_MAX; c_offset = S32_MAX; c_span = U31_MAX;
                    c_div = U31_MAX;
                end
                2: begin
                    c_scale = 32'sd0; c_offset = pick_word(); c_span = pick_u31();
                    c_div = pick_divisor();
                end
                3: begin
                    c_scale = 32'sd1; c_offset = 32'sd0; c_span = 31'd1; c_div = 31'd1;
                end
                5: begin
                    c_scale = -32'sd1; c_offset = pick_word(); c_span = pick_u31();
                    c_div = 31'd0;
                end
                default: begin
                    c_scale = pick_word(); c_offset = pick_word(); c_span = pick_u31();
                    c_div = pick_divisor();
                end
            endcase
            apply_config(c_scale, c_offset, c_span, c_div);
            gap_mode = gap_mode_t'(ph % 4);
            // Phase 4 runs without bubbles, so the long hold-off really backs up.
            if (ph == 4) begin
                hold_armed = 1'b1;
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                send_chunk(pick_word(), pick_u31(), 1'b0, 0, 0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
